// File: sv/msbp_pkg.sv
// Shared types and constants for the MSB-first bit field packer.
// Holds the request and response structs, operation codes and sizes.
// No dependencies; used by msb_first_bit_field_packer_core.
`timescale 1ns / 1ps

package msbp_pkg;

	// Buffer geometry and field limits.
	localparam int BUF_BYTES      = 32768;
	localparam int ADDR_W         = $clog2(BUF_BYTES);
	localparam int CUR_W          = ADDR_W + 4;
	localparam int POS_W          = ADDR_W + 1;
	localparam int MAX_FIELD_BITS = 32;
	localparam int COUNT_W        = 6;
	localparam int FRAME_W        = MAX_FIELD_BITS + 8;

	// Operation codes.
	localparam logic [2:0] OP_STORE  = 3'd0;
	localparam logic [2:0] OP_READ   = 3'd1;
	localparam logic [2:0] OP_SETCUR = 3'd2;
	localparam logic [2:0] OP_GET    = 3'd3;
	localparam logic [2:0] OP_PUT    = 3'd4;
	localparam logic [2:0] OP_ALIGN  = 3'd5;

	// One request as it arrives on the command port.
	typedef struct packed {
		logic [2:0]                op;
		logic [ADDR_W-1:0]         address;
		logic [7:0]                byte_in;
		logic [COUNT_W-1:0]        count;
		logic [MAX_FIELD_BITS-1:0] field_value;
	} req_t;

	// One response as it leaves on the result port.
	typedef struct packed {
		logic [MAX_FIELD_BITS-1:0] read_value;
		logic [POS_W-1:0]          byte_position;
		logic                      overrun;
	} rsp_t;

	// Bit cursor divided by eight, rounded up.
	function automatic logic [POS_W-1:0] ceil_byte(input logic [CUR_W-1:0] cur);
		return POS_W'(cur[CUR_W-1:3]) + POS_W'(|cur[2:0]);
	endfunction

endpackage

// File: sv/msb_first_bit_field_packer_core.sv
// Top level of the MSB-first bit field packer: byte buffer memory, bit cursor
// and the sequencer that walks the bytes of a field.
// Depends on msbp_pkg.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; its response shows
// on rsp for exactly one cycle with done high, and the receiver cannot hold
// it off. Store, set cursor, align, unused codes, zero-length fields and
// overrun cases answer in the cycle after the request and leave busy low.
// A byte read answers after a read-wait state. A get or put visits
// each byte the field touches through the single byte-wide buffer memory,
// one byte per cycle, and answers after the last one; it touches B bytes,
// B = ceil((cursor mod 8 + count) / 8), 1 to 5, and busy is high meanwhile.
// The buffer is not cleared after reset: reading a byte never stored gives
// an arbitrary value. The bit cursor resets to zero.
module msb_first_bit_field_packer_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  msbp_pkg::req_t req,
	output logic           done,
	output msbp_pkg::rsp_t rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_FIELD
	} state_t;

	state_t state_q;
	logic   done_q;
	msbp_pkg::rsp_t rsp_q;
	logic [msbp_pkg::CUR_W-1:0] cursor_q;
	logic [2:0] left_q;
	logic       is_put_q;

	// Field working registers.
	logic [msbp_pkg::ADDR_W-1:0]         addr_q;
	logic [msbp_pkg::FRAME_W-1:0]        frame_q;
	logic [msbp_pkg::FRAME_W-1:0]        fmask_q;
	logic [msbp_pkg::MAX_FIELD_BITS-1:0] gmask_q;
	logic [msbp_pkg::FRAME_W-9:0]        win_q;
	logic [2:0]                          trail_q;
	logic [msbp_pkg::CUR_W-1:0]          cursor_next_q;

	// Buffer memory and its ports.
	logic [7:0] byte_mem [msbp_pkg::BUF_BYTES];
	logic [7:0] rdata_s1;
	logic                        mem_we;
	logic [msbp_pkg::ADDR_W-1:0] mem_waddr;
	logic [7:0]                  mem_wdata;
	logic                        mem_re;
	logic [msbp_pkg::ADDR_W-1:0] mem_raddr;

	// Request decode.
	logic                                accept;
	logic [msbp_pkg::COUNT_W-1:0]        n_c;
	logic [msbp_pkg::COUNT_W-1:0]        span_c;
	logic [msbp_pkg::COUNT_W-1:0]        shift_c;
	logic [2:0]                          nbytes_c;
	logic [2:0]                          trail_c;
	logic [msbp_pkg::MAX_FIELD_BITS-1:0] gmask_c;
	logic                                fits_c;
	logic                                is_field_c;
	logic                                field_go_c;
	logic [msbp_pkg::POS_W-1:0]          pos_cur_c;
	logic [msbp_pkg::MAX_FIELD_BITS-1:0] get_val_c;
	logic [msbp_pkg::ADDR_W-1:0]         cur_byte_c;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign rsp    = rsp_q;

	// Field geometry from the cursor and the saturated count.
	always_comb begin
		n_c = (req.count > msbp_pkg::COUNT_W'(msbp_pkg::MAX_FIELD_BITS))
			? msbp_pkg::COUNT_W'(msbp_pkg::MAX_FIELD_BITS) : req.count;
		span_c     = msbp_pkg::COUNT_W'(cursor_q[2:0]) + n_c;
		nbytes_c   = 3'((span_c + msbp_pkg::COUNT_W'(7)) >> 3);
		trail_c    = 3'(3'd0 - span_c[2:0]);
		shift_c    = msbp_pkg::COUNT_W'(msbp_pkg::FRAME_W) - span_c;
		gmask_c    = msbp_pkg::MAX_FIELD_BITS'(
			((msbp_pkg::MAX_FIELD_BITS+1)'(1) << n_c) - (msbp_pkg::MAX_FIELD_BITS+1)'(1));
		fits_c     = ((msbp_pkg::CUR_W+1)'(cursor_q) + (msbp_pkg::CUR_W+1)'(n_c))
			<= (msbp_pkg::CUR_W+1)'(msbp_pkg::BUF_BYTES * 8);
		is_field_c = (req.op == msbp_pkg::OP_GET) || (req.op == msbp_pkg::OP_PUT);
		field_go_c = is_field_c && (n_c != '0) && fits_c;
		pos_cur_c  = msbp_pkg::ceil_byte(cursor_q);
		cur_byte_c = cursor_q[msbp_pkg::ADDR_W+2:3];
		get_val_c  = msbp_pkg::MAX_FIELD_BITS'({win_q, rdata_s1} >> trail_q) & gmask_q;
	end

	// Memory port control: stores and put write-back share the write port;
	// the read port fetches the next byte of a field while the current one
	// is written back, so the two never address the same entry.
	always_comb begin
		if (state_q == ST_FIELD) begin
			mem_we    = is_put_q;
			mem_waddr = addr_q;
			mem_re    = (left_q != '0);
			mem_raddr = addr_q + msbp_pkg::ADDR_W'(1);
		end else begin
			mem_we    = accept && (req.op == msbp_pkg::OP_STORE);
			mem_waddr = req.address;
			mem_re    = accept && ((req.op == msbp_pkg::OP_READ) || field_go_c);
			mem_raddr = (req.op == msbp_pkg::OP_READ) ? req.address : cur_byte_c;
		end
		mem_wdata = (state_q == ST_FIELD)
			? ((rdata_s1 & ~fmask_q[msbp_pkg::FRAME_W-1 -: 8])
				| (frame_q[msbp_pkg::FRAME_W-1 -: 8] & fmask_q[msbp_pkg::FRAME_W-1 -: 8]))
			: req.byte_in;
	end

	// Byte buffer with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			byte_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= byte_mem[mem_raddr];
		end
	end

	// Sequencer state, cursor and registered response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			rsp_q    <= '0;
			cursor_q <= '0;
			left_q   <= '0;
			is_put_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rsp_q.read_value <= '0;
						case (req.op) inside
							msbp_pkg::OP_READ: begin
								rsp_q.byte_position <= pos_cur_c;
								rsp_q.overrun       <= 1'b0;
								done_q              <= 1'b0;
								state_q             <= ST_RD_WAIT;
							end
							msbp_pkg::OP_SETCUR: begin
								cursor_q            <= {1'b0, req.address, 3'b000};
								rsp_q.byte_position <= msbp_pkg::POS_W'(req.address);
								rsp_q.overrun       <= 1'b0;
								done_q              <= 1'b1;
							end
							msbp_pkg::OP_GET, msbp_pkg::OP_PUT: begin
								rsp_q.byte_position <= pos_cur_c;
								if (field_go_c) begin
									rsp_q.overrun <= 1'b0;
									done_q        <= 1'b0;
									state_q       <= ST_FIELD;
									left_q        <= nbytes_c - 3'd1;
									is_put_q      <= (req.op == msbp_pkg::OP_PUT);
								end else begin
									rsp_q.overrun <= (n_c != '0);
									done_q        <= 1'b1;
								end
							end
							default: begin
								rsp_q.byte_position <= pos_cur_c;
								rsp_q.overrun       <= 1'b0;
								done_q              <= 1'b1;
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				ST_RD_WAIT: begin
					rsp_q.read_value <= msbp_pkg::MAX_FIELD_BITS'(rdata_s1);
					done_q           <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_FIELD: begin
					if (left_q == '0) begin
						rsp_q.read_value    <= is_put_q ? '0 : get_val_c;
						rsp_q.byte_position <= msbp_pkg::ceil_byte(cursor_next_q);
						cursor_q            <= cursor_next_q;
						done_q              <= 1'b1;
						state_q             <= ST_IDLE;
					end else begin
						left_q <= left_q - 3'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Field data path: the put frame and mask are MSB-aligned to the first
	// byte and shift up one byte per visit; get bytes shift into the window.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q        <= cur_byte_c;
			frame_q       <= msbp_pkg::FRAME_W'(req.field_value & gmask_c) << shift_c;
			fmask_q       <= msbp_pkg::FRAME_W'(gmask_c) << shift_c;
			gmask_q       <= gmask_c;
			trail_q       <= trail_c;
			win_q         <= '0;
			cursor_next_q <= cursor_q + msbp_pkg::CUR_W'(n_c);
		end else if (state_q == ST_FIELD) begin
			addr_q  <= addr_q + msbp_pkg::ADDR_W'(1);
			frame_q <= frame_q << 8;
			fmask_q <= fmask_q << 8;
			win_q   <= {win_q[msbp_pkg::FRAME_W-17:0], rdata_s1};
		end
	end

	// A response never coincides with a request still in progress.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("response strobe while busy");

	// Store, set cursor and align requests answer in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.op == msbp_pkg::OP_STORE || req.op == msbp_pkg::OP_SETCUR
			|| req.op == msbp_pkg::OP_ALIGN)) |=> (done && !busy))
		else $error("single-cycle request did not answer");

	// The cursor never moves past the end of the buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= msbp_pkg::CUR_W'(msbp_pkg::BUF_BYTES * 8))
		else $error("bit cursor beyond buffer end");

	// A field never touches more than five bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIELD) |-> (left_q <= 3'd4))
		else $error("field byte count out of range");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for msb_first_bit_field_packer_core.
// It predicts each response from a byte image and cursor kept in the bench,
// and checks every response in order. Depends on msbp_pkg and the core.
`timescale 1ns / 1ps

module testbench;

	// Codes the block leaves unused; they must answer like a no-op.
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam int RANDOM_REQS    = 1700;
	localparam int WINDOW         = 32;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 4000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy;
	msbp_pkg::req_t req = '0;
	logic  done;
	msbp_pkg::rsp_t rsp;

	// Planned requests and the responses they are predicted to give.
	msbp_pkg::req_t pending_reqs[$];
	msbp_pkg::rsp_t awaited_rsps[$];

	// Shadow of the cursor and of which bytes hold defined data, used only
	// while the request list is built.
	int unsigned plan_cursor;
	bit          plan_known [msbp_pkg::BUF_BYTES];

	// Byte image and cursor of the predictor.
	logic [7:0]                 image [msbp_pkg::BUF_BYTES];
	logic [msbp_pkg::CUR_W-1:0] image_cursor;

	int mismatches;
	int requests_taken;
	int responses_seen;
	int overruns_seen;
	int op_tally [8];
	int idle_cycles;
	int gap_left;
	int burst_left;

	msb_first_bit_field_packer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #1 clk = ~clk;

	// A byte address inside one of the two windows filled at the start.
	function automatic int unsigned window_address();
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, WINDOW - 1);
		return $urandom_range(msbp_pkg::BUF_BYTES - WINDOW, msbp_pkg::BUF_BYTES - 1);
	endfunction

	// Queue one request. A get or put that would touch a byte never written
	// becomes a cursor move into a window, and a read of such a byte becomes
	// a store, so no undefined byte is ever read.
	task automatic plan_request(input logic [2:0] op, input int unsigned address,
			input int unsigned byte_v, input int unsigned count,
			input logic [31:0] value);
		msbp_pkg::req_t r;
		int unsigned    n;
		int unsigned    k;
		bit             readable;
		n = (count > msbp_pkg::MAX_FIELD_BITS) ? msbp_pkg::MAX_FIELD_BITS : count;
		if ((op == msbp_pkg::OP_GET || op == msbp_pkg::OP_PUT) && n != 0 &&
				plan_cursor + n <= msbp_pkg::BUF_BYTES * 8) begin
			readable = 1'b1;
			for (k = plan_cursor >> 3; k <= (plan_cursor + n - 1) >> 3; k++)
				if (!plan_known[k])
					readable = 1'b0;
			if (readable) begin
				plan_cursor += n;
			end else begin
				op = msbp_pkg::OP_SETCUR;
				address = window_address();
			end
		end
		if (op == msbp_pkg::OP_READ && !plan_known[address])
			op = msbp_pkg::OP_STORE;
		if (op == msbp_pkg::OP_STORE)
			plan_known[address] = 1'b1;
		if (op == msbp_pkg::OP_SETCUR)
			plan_cursor = address * 8;
		r.op = op;
		r.address = msbp_pkg::ADDR_W'(address);
		r.byte_in = 8'(byte_v);
		r.count = msbp_pkg::COUNT_W'(count);
		r.field_value = value;
		pending_reqs.push_back(r);
	endtask

	// One random stretch of requests.
	task automatic plan_round();
		int unsigned    fields;
		int unsigned    base;
		int unsigned    widths [6];
		int unsigned    j;
		logic [2:0]     op_pick;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				// Pack a run of fields, rewind, and unpack them again.
				fields = $urandom_range(1, 6);
				base = window_address();
				plan_request(msbp_pkg::OP_SETCUR, base, 0, 0, 0);
				for (j = 0; j < fields; j++) begin
					widths[j] = $urandom_range(1, 32);
					plan_request(msbp_pkg::OP_PUT, 0, 0, widths[j], $urandom);
				end
				plan_request(msbp_pkg::OP_SETCUR, base, 0, 0, 0);
				for (j = 0; j < fields; j++)
					plan_request(msbp_pkg::OP_GET, 0, 0, widths[j], $urandom);
				if ($urandom_range(0, 1) == 0)
					plan_request(msbp_pkg::OP_ALIGN, $urandom, $urandom, $urandom,
						$urandom);
			end
			4: begin
				// Walk off the end of the buffer.
				plan_request(msbp_pkg::OP_SETCUR,
					$urandom_range(msbp_pkg::BUF_BYTES - 6, msbp_pkg::BUF_BYTES - 1),
					0, 0, 0);
				for (j = 0; j < 3; j++)
					plan_request($urandom_range(0, 1) ? msbp_pkg::OP_GET : msbp_pkg::OP_PUT,
						0, 0, $urandom_range(0, 63), $urandom);
			end
			5: begin
				if ($urandom_range(0, 1) == 0)
					plan_request(msbp_pkg::OP_READ, window_address(), 0, 0, 0);
				else
					plan_request(msbp_pkg::OP_STORE,
						$urandom_range(0, msbp_pkg::BUF_BYTES - 1),
						$urandom_range(0, 255), 0, 0);
			end
			default: begin
				// Noise: any code with arbitrary fields.
				op_pick = 3'($urandom_range(0, 7));
				plan_request(op_pick,
					$urandom_range(0, 1) ? window_address() :
						$urandom_range(0, msbp_pkg::BUF_BYTES - 1),
					$urandom_range(0, 255), $urandom_range(0, 63), $urandom);
			end
		endcase
	endtask

	// Apply one accepted request to the byte image and queue its response.
	task automatic advance_image(input msbp_pkg::req_t r);
		msbp_pkg::rsp_t want;
		int unsigned    n;
		int unsigned    cur;
		int unsigned    pos;
		int unsigned    i;
		want = '0;
		n = (r.count > msbp_pkg::MAX_FIELD_BITS) ? msbp_pkg::MAX_FIELD_BITS : r.count;
		cur = image_cursor;
		case (r.op) inside
			msbp_pkg::OP_STORE: begin
				if (r.address < msbp_pkg::BUF_BYTES)
					image[r.address] = r.byte_in;
				else
					want.overrun = 1'b1;
			end
			msbp_pkg::OP_READ: begin
				if (r.address < msbp_pkg::BUF_BYTES)
					want.read_value = 32'(image[r.address]);
				else
					want.overrun = 1'b1;
			end
			msbp_pkg::OP_SETCUR: begin
				if (r.address <= msbp_pkg::BUF_BYTES)
					cur = r.address * 8;
				else
					want.overrun = 1'b1;
			end
			msbp_pkg::OP_GET, msbp_pkg::OP_PUT: begin
				if (n != 0) begin
					if (cur + n <= msbp_pkg::BUF_BYTES * 8) begin
						// Bit 7 of each byte comes first.
						for (i = 0; i < n; i++) begin
							pos = cur + i;
							if (r.op == msbp_pkg::OP_GET)
								want.read_value = {want.read_value[30:0],
									image[pos >> 3][7 - (pos & 7)]};
							else
								image[pos >> 3][7 - (pos & 7)] = r.field_value[n - 1 - i];
						end
						cur += n;
					end else begin
						want.overrun = 1'b1;
					end
				end
			end
			default: ;
		endcase
		image_cursor = msbp_pkg::CUR_W'(cur);
		want.byte_position = msbp_pkg::POS_W'((cur + 7) >> 3);
		op_tally[r.op]++;
		if (want.overrun)
			overruns_seen++;
		awaited_rsps.push_back(want);
	endtask

	// Request driver: bursts of back-to-back requests with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			if (start && !busy) begin
				advance_image(req);
				requests_taken++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req <= pending_reqs.pop_front();
					start <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ?
							$urandom_range(60, 150) : $urandom_range(1, 25);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Response checker and watchdog.
	always @(posedge clk) begin
		msbp_pkg::rsp_t want;
		if (arst_n) begin
			if (done) begin
				responses_seen++;
				if (awaited_rsps.size() == 0) begin
					$display("%0t: response with no request waiting: got %p", $time, rsp);
					mismatches++;
				end else begin
					want = awaited_rsps.pop_front();
					if (rsp.read_value !== want.read_value) begin
						$display("%0t: read_value expected %h, got %h",
							$time, want.read_value, rsp.read_value);
						mismatches++;
					end
					if (rsp.byte_position !== want.byte_position) begin
						$display("%0t: byte_position expected %0d, got %0d",
							$time, want.byte_position, rsp.byte_position);
						mismatches++;
					end
					if (rsp.overrun !== want.overrun) begin
						$display("%0t: overrun expected %b, got %b",
							$time, want.overrun, rsp.overrun);
						mismatches++;
					end
				end
			end
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no request or response for %0d cycles", $time, idle_cycles);
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int unsigned a;
		plan_cursor = 0;
		image_cursor = '0;

		// Fill both windows so that fields there read defined data.
		for (a = 0; a < WINDOW; a++) begin
			plan_request(msbp_pkg::OP_STORE, a, $urandom_range(0, 255), 0, 0);
			plan_request(msbp_pkg::OP_STORE, msbp_pkg::BUF_BYTES - WINDOW + a,
				$urandom_range(0, 255), 0, 0);
		end

		// Directed requests: extremes, odd offsets, zero and oversized counts,
		// the cursor at the very end, overruns and the unused codes.
		plan_request(msbp_pkg::OP_STORE, 0, 8'h00, 0, 0);
		plan_request(msbp_pkg::OP_STORE, msbp_pkg::BUF_BYTES - 1, 8'hFF, 0, 0);
		plan_request(msbp_pkg::OP_READ, 0, 0, 0, 0);
		plan_request(msbp_pkg::OP_READ, msbp_pkg::BUF_BYTES - 1, 0, 0, 0);
		plan_request(msbp_pkg::OP_SETCUR, 0, 0, 0, 0);
		plan_request(msbp_pkg::OP_PUT, 0, 0, 32, 32'hFFFF_FFFF);
		plan_request(msbp_pkg::OP_PUT, 0, 0, 1, 32'h0);
		plan_request(msbp_pkg::OP_SETCUR, 0, 0, 0, 0);
		plan_request(msbp_pkg::OP_GET, 0, 0, 32, 0);
		plan_request(msbp_pkg::OP_GET, 0, 0, 1, 0);
		plan_request(msbp_pkg::OP_SETCUR, 3, 0, 0, 0);
		plan_request(msbp_pkg::OP_GET, 0, 0, 1, 0);
		plan_request(msbp_pkg::OP_PUT, 0, 0, 32, 32'h8000_0001);
		plan_request(msbp_pkg::OP_SETCUR, 3, 0, 0, 0);
		plan_request(msbp_pkg::OP_GET, 0, 0, 1, 0);
		plan_request(msbp_pkg::OP_GET, 0, 0, 63, 0);
		plan_request(msbp_pkg::OP_GET, 0, 0, 0, 0);
		plan_request(msbp_pkg::OP_PUT, 0, 0, 0, 32'hFFFF_FFFF);
		plan_request(msbp_pkg::OP_ALIGN, 0, 0, 0, 0);
		plan_request(msbp_pkg::OP_SETCUR, msbp_pkg::BUF_BYTES - 4, 0, 0, 0);
		plan_request(msbp_pkg::OP_GET, 0, 0, 31, 0);
		plan_request(msbp_pkg::OP_ALIGN, 0, 0, 0, 0);
		plan_request(msbp_pkg::OP_GET, 0, 0, 1, 0);
		plan_request(msbp_pkg::OP_GET, 0, 0, 1, 0);
		plan_request(msbp_pkg::OP_PUT, 0, 0, 5, 32'h1F);
		plan_request(OP_SPARE_LO, msbp_pkg::BUF_BYTES - 1, 8'hFF, 63, 32'hFFFF_FFFF);
		plan_request(OP_SPARE_HI, 0, 0, 32, 0);
		plan_request(msbp_pkg::OP_SETCUR, msbp_pkg::BUF_BYTES - 1, 0, 0, 0);

		a = pending_reqs.size() + RANDOM_REQS;
		while (pending_reqs.size() < a)
			plan_round();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() > 0 || start)
			@(negedge clk);
		while (awaited_rsps.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d responses to %0d requests, %0d of them overruns.",
			responses_seen, requests_taken, overruns_seen);
		$display("Mix: %0d store, %0d read, %0d set cursor, %0d get, %0d put, %0d align, %0d unused.",
			op_tally[msbp_pkg::OP_STORE], op_tally[msbp_pkg::OP_READ],
			op_tally[msbp_pkg::OP_SETCUR], op_tally[msbp_pkg::OP_GET],
			op_tally[msbp_pkg::OP_PUT], op_tally[msbp_pkg::OP_ALIGN],
			op_tally[OP_SPARE_LO] + op_tally[OP_SPARE_HI]);
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
